[rtl/core/aggregation_curve_analyzer_defines.svh]
// ----------------------------------------------------------------------------
// Aggregation curve analyzer assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef AGGREGATION_CURVE_ANALYZER_DEFINES_SVH
`define AGGREGATION_CURVE_ANALYZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ACA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aca check failed: label");

// next-cycle implication, disabled during reset
`define ACA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aca check failed: label");

`endif

[rtl/core/aca_pkg.sv]
// ----------------------------------------------------------------------------
// Aggregation curve analyzer package
// Shared widths, constants, command/status types and helpers.
// ----------------------------------------------------------------------------
package aca_pkg;

   // default sizes
   localparam int ACA_MAX_SAMPLES  = 4096;
   localparam int ACA_SLOPE_WINDOW = 5;
   localparam int ACA_RISE_RUN     = 3;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int MPS_W     = 32;
   localparam int SPM_W     = 24;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int OUT_IDX_W = 12;
   localparam int TIME_W    = 28;
   localparam int SLOPE_W   = 40;
   localparam int AREA_W    = 45;
   localparam int STATUS_W  = 2;
   localparam int RSP_W     = 184;
   localparam int LVL_W     = SAMPLE_W + 5;

   // register reset values
   localparam logic [MPS_W-1:0] MPS_RESET = 32'd71582788;
   localparam logic [SPM_W-1:0] SPM_RESET = 24'd15360;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MINUTES_PER_SAMPLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_MINUTE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MAX_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_AREA_NEG = 2'd2;

   // lag threshold: 10*y >= 9*baseline + max
   localparam int LAG_SCALE     = 10;
   localparam int LAG_BASE_MULT = 9;
   localparam logic signed [SAMPLE_W-1:0] MAX_LIMIT = 16'sd10000;

   // saturation limits
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [SLOPE_W-1:0] SLOPE_MAX = '1;

   typedef struct packed {
      logic take;
      logic walk_init;
      logic walk;
      logic mul;
      logic comb;
      logic div;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic div_done;
      logic out_free;
   } dp_sts_type;

   // sample reaches baseline plus a tenth of the rise
   function automatic logic level_met(input logic signed [SAMPLE_W-1:0] y,
                                      input logic signed [LVL_W-1:0] level);
      logic signed [LVL_W-1:0] scaled;
      scaled = LVL_W'(LAG_SCALE) * LVL_W'(y);
      return scaled >= level;
   endfunction

endpackage

[rtl/core/aggregation_curve_analyzer.sv]
// Sequence: after the last sample, the result is built by the walk over the n
// stored samples through the single read port, the multiply, the scale, the
// slope division by reciprocal multiplication (multiply, reciprocal, sum) and
// the load, which waits while an older result is still held.
// Throughput: one sample a cycle while streaming, none from walk to load.
// Reset is synchronous, active high.
// ----------------------------------------------------------------------------
// Aggregation curve analyzer top level
// Streams a curve in, reports maximum, lag, slope, area and status per curve.
// ----------------------------------------------------------------------------
module aggregation_curve_analyzer
   import aca_pkg::*;
#(
   parameter int MAX_SAMPLES  = ACA_MAX_SAMPLES,
   parameter int SLOPE_WINDOW = ACA_SLOPE_WINDOW,
   parameter int RISE_RUN     = ACA_RISE_RUN
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // sample
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // max_value, max_index, time_to_max, lag_index, lag_found, lag_time,
   // max_slope, area, status
   output logic [RSP_W-1:0]     rsp_tdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // controller
   aca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   aca_datapath #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .SLOPE_WINDOW (SLOPE_WINDOW),
      .RISE_RUN     (RISE_RUN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/aca_ctrl.sv]
// ----------------------------------------------------------------------------
// Aggregation curve analyzer controller
// Sequences streaming, buffer walk, multiply, divide and result load.
// ----------------------------------------------------------------------------
module aca_ctrl
   import aca_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_RUN,
      S_WALK,
      S_MUL,
      S_COMB,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_RUN: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/aca_datapath.sv]
// ----------------------------------------------------------------------------
// Aggregation curve analyzer datapath
// Curve buffer, running statistics, lag walk, products, slope scaling, result reg.
// ----------------------------------------------------------------------------
module aca_datapath
   import aca_pkg::*;
#(
   parameter int MAX_SAMPLES  = ACA_MAX_SAMPLES,
   parameter int SLOPE_WINDOW = ACA_SLOPE_WINDOW,
   parameter int RISE_RUN     = ACA_RISE_RUN
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [SAMPLE_W-1:0]  req_tdata,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata
);

   localparam int IDX_W     = $clog2(MAX_SAMPLES);
   localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int PAIR_W    = SAMPLE_W + 1 + IDX_W;
   localparam int NUM_W     = SAMPLE_W + 2 + 3 * $clog2(SLOPE_WINDOW);
   localparam int SUM_J     = SLOPE_WINDOW * (SLOPE_WINDOW - 1) / 2;
   localparam int SUM_JJ    = (SLOPE_WINDOW - 1) * SLOPE_WINDOW * (2 * SLOPE_WINDOW - 1) / 6;
   localparam int SLOPE_DEN = SLOPE_WINDOW * SUM_JJ - SUM_J * SUM_J;
   localparam int DEN_W     = $clog2(SLOPE_DEN + 1);
   localparam int SPROD_W   = NUM_W + SPM_W;
   localparam int TPROD_W   = IDX_W + MPS_W;
   localparam int ALO_W     = PAIR_W + 17;
   localparam int AREA_PW   = PAIR_W + MPS_W + 1;

   // slope scaling by reciprocal multiplication
   localparam int BEST_W    = NUM_W - 1;
   localparam int S1        = BEST_W + DEN_W;
   localparam int R1_W      = S1 - DEN_W + 2;
   localparam int BQP_W     = BEST_W + R1_W;
   localparam int RP_W      = DEN_W + SPM_W;
   localparam int S2        = RP_W + DEN_W;
   localparam int R2_W      = S2 - DEN_W + 2;
   localparam int LQP_W     = RP_W + R2_W;
   localparam longint RECIP1 = ((longint'(1) <<< S1) + longint'(SLOPE_DEN) - 1)
                               / longint'(SLOPE_DEN);
   localparam longint RECIP2 = ((longint'(1) <<< S2) + longint'(SLOPE_DEN) - 1)
                               / longint'(SLOPE_DEN);
   localparam int DCNT_W    = 2;
   localparam logic [DCNT_W-1:0] DSTEP_MUL   = 2'd3;
   localparam logic [DCNT_W-1:0] DSTEP_RECIP = 2'd2;
   localparam logic [DCNT_W-1:0] DSTEP_SUM   = 2'd1;

   localparam logic signed [AREA_PW-1:0] AREA_HI = AREA_PW'((64'sd1 <<< (AREA_W - 1)) - 1);
   localparam logic signed [AREA_PW-1:0] AREA_LO = AREA_PW'(-(64'sd1 <<< (AREA_W - 1)));

   // configuration registers
   logic [MPS_W-1:0] mps_ff;
   logic [SPM_W-1:0] spm_ff;

   // running curve state
   logic [CNT_W-1:0]           count_ff;
   logic signed [SAMPLE_W-1:0] base_ff;
   logic signed [SAMPLE_W-1:0] max_ff;
   logic [IDX_W-1:0]           max_idx_ff;
   logic signed [PAIR_W-1:0]   pair_ff;
   logic signed [NUM_W-1:0]    best_ff;
   logic signed [SAMPLE_W-1:0] win_ff [SLOPE_WINDOW];

   // curve buffer
   logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
   logic signed [SAMPLE_W-1:0] mem_q_ff;

   // walk state
   logic [CNT_W-1:0]           rd_ptr_ff;
   logic                       rd_vld_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic signed [SAMPLE_W-1:0] rwin_ff [RISE_RUN];
   logic                       hit1_ff, hit2_ff;
   logic [IDX_W-1:0]           lag1_ff, lag2_ff;

   // products and results
   logic [TPROD_W-1:0]        tmax_p_ff, tlag_p_ff;
   logic [IDX_W-1:0]          lag_ff;
   logic                      found_ff;
   logic [BQP_W-1:0]          bq_p_ff;
   logic [BEST_W-1:0]         bq_ff;
   logic [DEN_W-1:0]          br_ff;
   logic [SPROD_W-1:0]        hi_ff;
   logic [RP_W-1:0]           lo_ff;
   logic [LQP_W-1:0]          lo_qp_ff;
   logic signed [ALO_W-1:0]   alo_ff, ahi_ff;
   logic [TIME_W-1:0]         tmax_ff, tlag_ff;
   logic signed [AREA_W-1:0]  area_ff;
   logic [SPROD_W-1:0]        divq_ff;
   logic [DCNT_W-1:0]         dcnt_ff;
   logic                      rsp_vld_ff;
   logic [RSP_W-1:0]          rsp_data_ff;

   logic signed [SAMPLE_W-1:0] sample;
   logic                       full;
   logic signed [NUM_W-1:0]    sum_y, sum_jy, slope_num;
   logic signed [LVL_W-1:0]    level;
   logic                       rd_issue;
   logic signed [SAMPLE_W-1:0] cand [RISE_RUN];
   logic                       rise_ok;
   logic [IDX_W-1:0]           lag_sel;
   logic signed [AREA_PW-1:0]  area_full, area_q;
   logic [TPROD_W-1:0]         tmax_sh, tlag_sh;
   logic [BEST_W-1:0]          bq_now, br_now;
   logic [SLOPE_W-1:0]         slope_out;
   logic [STATUS_W-1:0]        status;

   assign sample = $signed(req_tdata);
   assign full   = (count_ff == CNT_W'(MAX_SAMPLES));
   assign level  = LVL_W'(LAG_BASE_MULT) * LVL_W'(base_ff) + LVL_W'(max_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mps_ff <= MPS_RESET;
         spm_ff <= SPM_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MINUTES_PER_SAMPLE: mps_ff <= csr_wdata[MPS_W-1:0];
            CSR_SAMPLES_PER_MINUTE: spm_ff <= csr_wdata[SPM_W-1:0];
            default: ;
         endcase
      end
   end

   // window slope numerator over the previous samples
   always_comb begin
      sum_y  = '0;
      sum_jy = '0;
      for (int j = 0; j < SLOPE_WINDOW; j++) begin
         sum_y  = sum_y + NUM_W'(win_ff[j]);
         sum_jy = sum_jy + NUM_W'(j) * NUM_W'(win_ff[j]);
      end
      slope_num = NUM_W'(SLOPE_WINDOW) * sum_jy - NUM_W'(SUM_J) * sum_y;
   end

   // running statistics while the curve streams in
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         count_ff   <= '0;
         base_ff    <= '0;
         max_ff     <= '0;
         max_idx_ff <= '0;
         pair_ff    <= '0;
         best_ff    <= '0;
         for (int j = 0; j < SLOPE_WINDOW; j++) begin
            win_ff[j] <= '0;
         end
      end else if (cmd.take && !full) begin
         if (count_ff == '0) begin
            base_ff    <= sample;
            max_ff     <= sample;
            max_idx_ff <= '0;
         end else begin
            if (sample > max_ff) begin
               max_ff     <= sample;
               max_idx_ff <= count_ff[IDX_W-1:0];
            end
            pair_ff <= pair_ff + PAIR_W'(sample) + PAIR_W'(win_ff[SLOPE_WINDOW-1]);
         end
         if (count_ff >= CNT_W'(SLOPE_WINDOW) && slope_num > best_ff) begin
            best_ff <= slope_num;
         end
         for (int j = 0; j < SLOPE_WINDOW - 1; j++) begin
            win_ff[j] <= win_ff[j+1];
         end
         win_ff[SLOPE_WINDOW-1] <= sample;
         count_ff <= count_ff + 1'b1;
      end
   end

   // curve buffer: write while streaming, read while walking
   assign rd_issue = cmd.walk && (rd_ptr_ff < count_ff);

   always_ff @(posedge clock) begin
      if (cmd.take && !full) begin
         mem[count_ff[IDX_W-1:0]] <= sample;
      end
      if (rd_issue) begin
         mem_q_ff <= mem[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   // candidate run ending at the sample just read
   always_comb begin
      for (int j = 0; j < RISE_RUN - 1; j++) begin
         cand[j] = rwin_ff[j+1];
      end
      cand[RISE_RUN-1] = mem_q_ff;
      rise_ok = 1'b1;
      for (int j = 0; j < RISE_RUN - 1; j++) begin
         if (cand[j+1] <= cand[j]) begin
            rise_ok = 1'b0;
         end
      end
   end

   // lag walk
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         rd_vld_ff <= 1'b0;
         hit1_ff   <= 1'b0;
         hit2_ff   <= 1'b0;
      end else if (cmd.walk_init) begin
         rd_ptr_ff <= '0;
         rd_vld_ff <= 1'b0;
         hit1_ff   <= 1'b0;
         hit2_ff   <= 1'b0;
      end else if (cmd.walk) begin
         rd_vld_ff <= rd_issue;
         if (rd_issue) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
            rd_idx_ff <= rd_ptr_ff[IDX_W-1:0];
         end
         if (rd_vld_ff) begin
            for (int j = 0; j < RISE_RUN - 1; j++) begin
               rwin_ff[j] <= rwin_ff[j+1];
            end
            rwin_ff[RISE_RUN-1] <= mem_q_ff;
            // fallback rule: first sample at the level
            if (!hit2_ff && level_met(mem_q_ff, level)) begin
               hit2_ff <= 1'b1;
               lag2_ff <= rd_idx_ff;
            end
            // main rule: run of strict rises starting at the level
            if (!hit1_ff && rd_idx_ff >= IDX_W'(RISE_RUN - 1)
                && (CNT_W'(rd_idx_ff) + 1'b1) < count_ff
                && rise_ok && level_met(cand[0], level)) begin
               hit1_ff <= 1'b1;
               lag1_ff <= rd_idx_ff - IDX_W'(RISE_RUN - 1);
            end
         end
      end
   end

   assign lag_sel = hit1_ff ? lag1_ff : (hit2_ff ? lag2_ff : '0);

   // products: time, lag and slope quotient, area as two partial products
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         tmax_p_ff <= TPROD_W'(max_idx_ff) * TPROD_W'(mps_ff);
         tlag_p_ff <= TPROD_W'(lag_sel) * TPROD_W'(mps_ff);
         lag_ff    <= lag_sel;
         found_ff  <= hit1_ff || hit2_ff;
         bq_p_ff   <= BQP_W'(best_ff[BEST_W-1:0]) * BQP_W'(RECIP1);
         alo_ff    <= ALO_W'(pair_ff) * ALO_W'($signed({1'b0, mps_ff[15:0]}));
         ahi_ff    <= ALO_W'(pair_ff) * ALO_W'($signed({1'b0, mps_ff[31:16]}));
      end
   end

   // combine partial products, scale and saturate
   always_comb begin
      area_full = (AREA_PW'(ahi_ff) <<< 16) + AREA_PW'(alo_ff);
      area_q    = area_full >>> 17;
      tmax_sh   = tmax_p_ff >> 16;
      tlag_sh   = tlag_p_ff >> 16;
      bq_now    = BEST_W'(bq_p_ff >> S1);
      br_now    = best_ff[BEST_W-1:0] - bq_now * BEST_W'(SLOPE_DEN);
   end

   always_ff @(posedge clock) begin
      if (cmd.comb) begin
         tmax_ff <= (tmax_sh > TPROD_W'(TIME_MAX)) ? TIME_MAX : tmax_sh[TIME_W-1:0];
         if (!found_ff) begin
            tlag_ff <= '0;
         end else begin
            tlag_ff <= (tlag_sh > TPROD_W'(TIME_MAX)) ? TIME_MAX : tlag_sh[TIME_W-1:0];
         end
         if (area_q > AREA_HI) begin
            area_ff <= AREA_HI[AREA_W-1:0];
         end else if (area_q < AREA_LO) begin
            area_ff <= AREA_LO[AREA_W-1:0];
         end else begin
            area_ff <= area_q[AREA_W-1:0];
         end
      end
   end

   // slope scaling: best = q * den + r, so the result is q * spm + (r * spm) / den
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.comb) begin
         dcnt_ff <= DSTEP_MUL;
         bq_ff   <= bq_now;
         br_ff   <= br_now[DEN_W-1:0];
      end else if (cmd.div && dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         case (dcnt_ff)
            DSTEP_MUL: begin
               hi_ff <= SPROD_W'(bq_ff) * SPROD_W'(spm_ff);
               lo_ff <= RP_W'(br_ff) * RP_W'(spm_ff);
            end
            DSTEP_RECIP: begin
               lo_qp_ff <= LQP_W'(lo_ff) * LQP_W'(RECIP2);
            end
            DSTEP_SUM: begin
               divq_ff <= hi_ff + SPROD_W'(lo_qp_ff >> S2);
            end
            default: ;
         endcase
      end
   end

   assign slope_out = (divq_ff > SPROD_W'(SLOPE_MAX)) ? SLOPE_MAX : divq_ff[SLOPE_W-1:0];

   // status code
   always_comb begin
      if (max_ff > MAX_LIMIT || max_ff < 0) begin
         status = STATUS_MAX_BAD;
      end else if (area_ff < 0) begin
         status = STATUS_AREA_NEG;
      end else begin
         status = STATUS_DONE;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= {status, area_ff, slope_out, tlag_ff, found_ff,
                         OUT_IDX_W'(lag_ff), tmax_ff, OUT_IDX_W'(max_idx_ff), max_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.walk_done = (rd_ptr_ff == count_ff) && !rd_vld_ff;
   assign sts.div_done  = (dcnt_ff == '0);
   assign sts.out_free  = !rsp_vld_ff || rsp_tready;

endmodule

[rtl/core/aca_checker.sv]
// ----------------------------------------------------------------------------
// Aggregation curve analyzer checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "aggregation_curve_analyzer_defines.svh"

module aca_checker
   import aca_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 req_tlast,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_W-1:0]     rsp_tdata
);

   logic [STATUS_W-1:0] rsp_status;
   logic                max_bad;

   assign rsp_status = rsp_tdata[RSP_W-1 -: STATUS_W];
   assign max_bad    = rsp_tdata[SAMPLE_W-1] || ($signed(rsp_tdata[SAMPLE_W-1:0]) > MAX_LIMIT);

   // closing transaction starts the walk, input stalls
   `ACA_ASSERT_NEXT(a_last_stalls, req_tvalid && req_tready && req_tlast, !req_tready)

   // a result only appears out of the walk phase
   `ACA_ASSERT_IMPL(a_rsp_after_walk, $rose(rsp_tvalid), !$past(req_tready))

   // status flags an out of range maximum exactly
   `ACA_ASSERT_IMPL(a_status_max, rsp_tvalid, (rsp_status == STATUS_MAX_BAD) == max_bad)

   // stalled result holds
   `ACA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind aggregation_curve_analyzer aca_checker u_aca_checker (.*);
